// ===== rtl/htfd_pkg.sv =====
// shared types, constants and crc helper for the humidity/temperature frame decoder
`timescale 1ns / 1ps
package htfd_pkg;

    // crc-8 used on each 16-bit sensor word
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // result field widths
    localparam int TEMP_W    = 15;
    localparam int HUMID_W   = 14;
    localparam int AGE_OUT_W = 32;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // byte positions within a six-byte response
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // what the back end does with one queued word
    typedef enum logic [1:0] {
        K_NOP  = 2'd0,
        K_TICK = 2'd1,
        K_GOOD = 2'd2,
        K_BAD  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic signed [TEMP_W-1:0]   temp;
        logic [HUMID_W-1:0]         humid;
    } t_entry;

    // one byte through the crc-8 shift register, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/humidity_temp_frame_decoder_unit.sv =====
// top level of the humidity/temperature frame decoder
`timescale 1ns / 1ps
// Decodes six-byte temperature/humidity responses (temperature word, crc, humidity word,
// crc; crc-8 poly 0x31, init 0xFF) into centi-degrees and centi-percent, and keeps a
// saturating millisecond age of the last good reading. Every input word (byte or tick)
// yields exactly one result word carrying the state after that word; tlast marks the
// word that completed a response. One word per clock is sustained while the output takes
// every result; a result passes through the queue and then the result register. Each
// word's scaling multiply runs in the front end when the low byte of that word arrives,
// and the divide by full scale is a shift with one correction step, so no path holds
// more than one multiply or a few short adds and compares. The queue and result register
// let the input stall without stopping the output; an output stall stops the input once
// the queue is full.
module humidity_temp_frame_decoder_unit
    import htfd_pkg::*;
#(
    parameter int AGE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,     // sensor_enabled
    // input words
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,      // [7:0] data_byte
    input  logic [1:0]   i_s_tuser,      // [0] op, [1] frame_start
    // result words
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,      // [14:0] temp_centi, [28:15] humid_centi,
                                         // [60:29] age_ms, [63:61] zero
    output logic [1:0]   o_m_tuser,      // [0] reading_valid, [1] crc_error
    output logic         o_m_tlast       // frame_done
);

    logic                      w_q_ready;
    logic                      w_push;
    t_entry                    w_push_entry;
    logic                      w_q_valid;
    t_entry                    w_q_entry;
    logic                      w_pop;
    logic                      w_reading_valid;
    logic signed [TEMP_W-1:0]  w_temp;
    logic [HUMID_W-1:0]        w_humid;
    logic [AGE_OUT_W-1:0]      w_age;
    logic                      w_done;
    logic                      w_err;

    assign o_cfg_ready = 1'b1;

    htfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser[0]),
        .i_data      (i_s_tdata),
        .i_start     (i_s_tuser[1]),
        .i_q_ready   (w_q_ready),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    htfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    htfd_back #(
        .AGE_BITS (AGE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .i_entry         (w_q_entry),
        .o_pop           (w_pop),
        .i_m_tready      (i_m_tready),
        .o_valid         (o_m_tvalid),
        .o_reading_valid (w_reading_valid),
        .o_temp          (w_temp),
        .o_humid         (w_humid),
        .o_age           (w_age),
        .o_done          (w_done),
        .o_err           (w_err)
    );

    // pack the result word
    assign o_m_tdata = {3'b000, w_age, w_humid, w_temp};
    assign o_m_tuser = {w_err, w_reading_valid};
    assign o_m_tlast = w_done;

    // a crc failure is only ever reported on the word that ends a response
    a_err_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_err |-> w_done)
        else $error("crc error flagged on a word that did not end a response");

    // a good response leaves a fresh, valid reading
    a_good_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_done && !w_err |-> w_reading_valid && (w_age == '0))
        else $error("good response did not refresh the reading");

    // scaled humidity never exceeds full scale
    a_humid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && (w_push_entry.kind == K_GOOD) |-> (w_push_entry.humid <= 14'd10000))
        else $error("humidity beyond full scale");

    // stored temperature stays inside the sensor range
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_temp >= -15'sd4500) && (w_temp <= 15'sd13000))
        else $error("temperature outside sensor range");

endmodule

// ===== rtl/htfd_front.sv =====
// front end: takes words, tracks the response, checks crcs and scales readings
`timescale 1ns / 1ps
module htfd_front
    import htfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    input  logic        i_cfg_data,
    // incoming word
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data,
    input  logic        i_start,
    // to the queue
    input  logic        i_q_ready,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam int PROD_W = 31;
    localparam int Q_W    = PROD_W - 16;
    localparam logic [PROD_W-1:0] TEMP_GAIN  = PROD_W'(17500);
    localparam logic [PROD_W-1:0] HUMID_GAIN = PROD_W'(10000);
    localparam logic [16:0]       FULL_SCALE = 17'd65535;
    localparam logic [Q_W-1:0]    TEMP_OFS   = Q_W'(4500);
    localparam logic [Q_W-1:0]    HUMID_MAX  = Q_W'(10000);

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           rem_nz;
    } t_quot;

    // floor division by 65535: estimate with a shift, then one correction step
    function automatic t_quot div_full_scale(input logic [PROD_W-1:0] p);
        t_quot      res;
        logic [16:0] r_est;
        res.q  = p[PROD_W-1:16];
        r_est  = {1'b0, p[15:0]} + 17'(res.q);
        if (r_est >= FULL_SCALE) begin
            res.q = res.q + 1'b1;
            r_est = r_est - FULL_SCALE;
        end
        res.rem_nz = (r_est != 17'd0);
        return res;
    endfunction

    logic                     r_en;
    logic [2:0]               r_pos;
    logic [2:0]               n_pos;
    logic [7:0]               r_crc;
    logic                     r_t_ok;
    logic [7:0]               r_t_hi;
    logic [7:0]               r_h_hi;
    logic [PROD_W-1:0]        r_tprod;
    logic [PROD_W-1:0]        r_hprod;
    logic signed [TEMP_W-1:0] r_temp;

    logic [2:0]               w_pos;
    logic                     w_accept;
    t_quot                    w_tq;
    t_quot                    w_hq;
    logic signed [15:0]       w_t16;
    logic [HUMID_W-1:0]       w_humid;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;
    assign o_push   = w_accept;

    // position of this byte; a start mark always restarts the response
    always_comb begin
        w_pos = i_start ? POS_T_HI : r_pos;
        if (w_pos > POS_H_CRC) begin
            w_pos = POS_T_HI;
        end
        n_pos = r_pos;
        if (i_op == OP_BYTE && r_en) begin
            n_pos = (w_pos == POS_H_CRC) ? POS_T_HI : w_pos + 3'd1;
        end
    end

    // temperature: trunc(q - 4500 + rem/65535) toward zero
    always_comb begin
        w_tq  = div_full_scale(r_tprod);
        w_t16 = signed'(16'(w_tq.q)) - signed'(16'(TEMP_OFS));
        if (w_tq.q < TEMP_OFS && w_tq.rem_nz) begin
            w_t16 = w_t16 + 16'sd1;
        end
    end

    // humidity: floor, capped at full scale
    always_comb begin
        w_hq = div_full_scale(r_hprod);
        if (w_hq.q > HUMID_MAX) begin
            w_humid = HUMID_W'(HUMID_MAX);
        end else begin
            w_humid = w_hq.q[HUMID_W-1:0];
        end
    end

    // classify the word for the back end
    always_comb begin
        o_entry.kind  = K_NOP;
        o_entry.temp  = r_temp;
        o_entry.humid = w_humid;
        if (i_op == OP_TICK) begin
            o_entry.kind = K_TICK;
        end else if (r_en && w_pos == POS_H_CRC) begin
            o_entry.kind = (r_t_ok && r_crc == i_data) ? K_GOOD : K_BAD;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b1;
            r_pos <= POS_T_HI;
        end else begin
            if (i_cfg_valid) begin
                r_en <= i_cfg_data;
            end
            if (w_accept) begin
                r_pos <= n_pos;
            end
        end
    end

    // held words, running crc and scaled products
    always_ff @(posedge i_clk) begin
        if (w_accept && i_op == OP_BYTE && r_en) begin
            case (w_pos)
                POS_T_HI: begin
                    r_t_hi <= i_data;
                    r_crc  <= crc8_byte(CRC_INIT, i_data);
                end
                POS_T_LO: begin
                    r_tprod <= TEMP_GAIN * PROD_W'({r_t_hi, i_data});
                    r_crc   <= crc8_byte(r_crc, i_data);
                end
                POS_T_CRC: begin
                    r_t_ok <= (r_crc == i_data);
                    r_temp <= w_t16[TEMP_W-1:0];
                end
                POS_H_HI: begin
                    r_h_hi <= i_data;
                    r_crc  <= crc8_byte(CRC_INIT, i_data);
                end
                POS_H_LO: begin
                    r_hprod <= HUMID_GAIN * PROD_W'({r_h_hi, i_data});
                    r_crc   <= crc8_byte(r_crc, i_data);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/htfd_queue.sv =====
// two-entry queue between the front and back ends
`timescale 1ns / 1ps
module htfd_queue
    import htfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    output logic    o_ready,
    output logic    o_valid,
    output t_entry  o_entry,
    input  logic    i_pop
);

    localparam int DEPTH = 2;

    t_entry      r_mem [DEPTH];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_ready = (r_count != 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd];

    // fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== rtl/htfd_back.sv =====
// back end: applies queued words to the stored reading and age, holds the result
`timescale 1ns / 1ps
module htfd_back
    import htfd_pkg::*;
#(
    parameter int AGE_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // from the queue
    input  logic                      i_valid,
    input  t_entry                    i_entry,
    output logic                      o_pop,
    // result register
    input  logic                      i_m_tready,
    output logic                      o_valid,
    output logic                      o_reading_valid,
    output logic signed [TEMP_W-1:0]  o_temp,
    output logic [HUMID_W-1:0]        o_humid,
    output logic [AGE_OUT_W-1:0]      o_age,
    output logic                      o_done,
    output logic                      o_err
);

    logic                      r_have;
    logic                      n_have;
    logic signed [TEMP_W-1:0]  r_temp;
    logic signed [TEMP_W-1:0]  n_temp;
    logic [HUMID_W-1:0]        r_humid;
    logic [HUMID_W-1:0]        n_humid;
    logic [AGE_BITS-1:0]       r_age;
    logic [AGE_BITS-1:0]       n_age;
    logic [AGE_OUT_W-1:0]      w_age_out;
    logic                      r_out_valid;

    assign o_pop   = i_valid && (!r_out_valid || i_m_tready);
    assign o_valid = r_out_valid;

    // state after the popped word
    always_comb begin
        n_have  = r_have;
        n_temp  = r_temp;
        n_humid = r_humid;
        n_age   = r_age;
        case (i_entry.kind)
            K_TICK: begin
                if (!(&r_age)) begin
                    n_age = r_age + 1'b1;
                end
            end
            K_GOOD: begin
                n_have  = 1'b1;
                n_temp  = i_entry.temp;
                n_humid = i_entry.humid;
                n_age   = '0;
            end
            default: begin
            end
        endcase
    end

    // age as shown, saturated to the port width
    generate
        if (AGE_BITS > AGE_OUT_W) begin : g_age_sat
            assign w_age_out = (|n_age[AGE_BITS-1:AGE_OUT_W]) ? '1 : n_age[AGE_OUT_W-1:0];
        end else begin : g_age_ext
            assign w_age_out = AGE_OUT_W'(n_age);
        end
    endgenerate

    // reading state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_temp      <= '0;
            r_humid     <= '0;
            r_age       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have  <= n_have;
                r_temp  <= n_temp;
                r_humid <= n_humid;
                r_age   <= n_age;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_reading_valid <= n_have;
            o_temp          <= n_temp;
            o_humid         <= n_humid;
            o_age           <= w_age_out;
            o_done          <= (i_entry.kind == K_GOOD) || (i_entry.kind == K_BAD);
            o_err           <= (i_entry.kind == K_BAD);
        end
    end

endmodule

// ===== verif/htfd_checker.sv =====
// sensor frame decoder checker: predicts each result word from the accepted input words
`timescale 1ns / 1ps
package htfd_tb_pkg;

    import htfd_pkg::*;

    // crc-8 of one 16-bit sensor word, bit-serial, msb first
    function automatic logic [7:0] sensor_crc8(input logic [15:0] word);
        logic [7:0] rem;
        rem = CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            if (rem[7] ^ word[i]) begin
                rem = {rem[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                rem = {rem[6:0], 1'b0};
            end
        end
        return rem;
    endfunction

endpackage

module htfd_checker
    import htfd_pkg::*;
    import htfd_tb_pkg::*;
#(
    parameter int AGE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic         i_cfg_data,     // sensor_enabled
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,      // [7:0] data_byte
    input  logic [1:0]   i_s_tuser,      // [0] op, [1] frame_start
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [63:0]  i_m_tdata,      // [14:0] temp_centi, [28:15] humid_centi,
                                         // [60:29] age_ms, [63:61] zero
    input  logic [1:0]   i_m_tuser,      // [0] reading_valid, [1] crc_error
    input  logic         i_m_tlast,      // frame_done
    output int           o_mismatches,
    output int           o_outstanding
);

    localparam longint unsigned AGE_MAX = (AGE_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : ((64'd1 << AGE_BITS) - 64'd1);

    typedef struct packed {
        logic                       reading_valid;
        logic signed [TEMP_W-1:0]   temp_centi;
        logic [HUMID_W-1:0]         humid_centi;
        logic [AGE_OUT_W-1:0]       age_ms;
        logic                       frame_done;
        logic                       crc_error;
    } t_reading;

    // decoder state as the checker sees it
    logic                       sensor_on;
    logic [2:0]                 byte_pos;
    logic [7:0]                 held [0:4];
    logic signed [TEMP_W-1:0]   last_temp;
    logic [HUMID_W-1:0]         last_humid;
    logic                       have_reading;
    longint unsigned            age_count;
    t_reading                   readings_due[$];
    int                         mismatch_count;

    // apply one input word to the state and form the reading it should produce
    task automatic decode_sensor_word(input logic op, input logic [7:0] data,
                                      input logic start, output t_reading r);
        logic [2:0]  pos;
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        longint      t_num;
        longint      h_num;
        r = '0;
        if (op == OP_TICK) begin
            if (age_count < AGE_MAX) begin
                age_count++;
            end
        end else if (sensor_on) begin
            pos = start ? POS_T_HI : byte_pos;
            if (pos > POS_H_CRC) begin
                pos = POS_T_HI;
            end
            if (pos != POS_H_CRC) begin
                held[pos] = data;
                byte_pos  = pos + 3'd1;
            end else begin
                r.frame_done = 1'b1;
                byte_pos     = POS_T_HI;
                t_raw = {held[POS_T_HI], held[POS_T_LO]};
                h_raw = {held[POS_H_HI], held[POS_H_LO]};
                if (sensor_crc8(t_raw) != held[POS_T_CRC] || sensor_crc8(h_raw) != data) begin
                    r.crc_error = 1'b1;
                end else begin
                    // signed divide truncates toward zero
                    t_num = (longint'(17500) * longint'(t_raw) - longint'(4500) * 65535) / 65535;
                    h_num = (longint'(h_raw) * 10000) / 65535;
                    if (h_num > 10000) begin
                        h_num = 10000;
                    end
                    last_temp    = t_num[TEMP_W-1:0];
                    last_humid   = h_num[HUMID_W-1:0];
                    have_reading = 1'b1;
                    age_count    = 0;
                end
            end
        end
        r.reading_valid = have_reading;
        r.temp_centi    = last_temp;
        r.humid_centi   = last_humid;
        r.age_ms        = (age_count > 64'hFFFF_FFFF) ? '1 : age_count[AGE_OUT_W-1:0];
    endtask

    task automatic check_field(input string field, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
            end
        end
    endtask

    // track config, predict on every input word, compare every result word
    always @(posedge i_clk) begin : watch
        t_reading want;
        t_reading seen;
        if (!i_rst_n) begin
            sensor_on    = 1'b1;
            byte_pos     = POS_T_HI;
            for (int k = 0; k < 5; k++) begin
                held[k] = 8'h00;
            end
            last_temp    = '0;
            last_humid   = '0;
            have_reading = 1'b0;
            age_count    = 0;
            readings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                sensor_on = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_sensor_word(i_s_tuser[0], i_s_tdata, i_s_tuser[1], want);
                readings_due.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.reading_valid = i_m_tuser[0];
                seen.crc_error     = i_m_tuser[1];
                seen.frame_done    = i_m_tlast;
                seen.temp_centi    = i_m_tdata[14:0];
                seen.humid_centi   = i_m_tdata[28:15];
                seen.age_ms        = i_m_tdata[60:29];
                if (readings_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result word with nothing expected: tdata %h tuser %b tlast %b",
                                 i_m_tdata, i_m_tuser, i_m_tlast);
                    end
                end else begin
                    want = readings_due.pop_front();
                    check_field("reading_valid", want.reading_valid, seen.reading_valid);
                    check_field("temp_centi", longint'(want.temp_centi),
                                longint'(seen.temp_centi));
                    check_field("humid_centi", want.humid_centi, seen.humid_centi);
                    check_field("age_ms", want.age_ms, seen.age_ms);
                    check_field("frame_done", want.frame_done, seen.frame_done);
                    check_field("crc_error", want.crc_error, seen.crc_error);
                end
            end
        end
        o_mismatches  = mismatch_count;
        o_outstanding = readings_due.size();
    end

    initial begin
        mismatch_count = 0;
        o_mismatches   = 0;
        o_outstanding  = 0;
    end

endmodule

// ===== verif/tb_humidity_temp_frame_decoder_unit.sv =====
// testbench top for the humidity/temperature frame decoder: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_humidity_temp_frame_decoder_unit;

    import htfd_pkg::*;
    import htfd_tb_pkg::*;

    localparam int AGE_BITS    = 32;
    localparam int STALL_LIMIT = 1000;
    localparam int SINK_HOLD   = 100;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;

    int mismatches;
    int outstanding;
    int words_sent;
    int stalled_cycles;
    bit src_gaps;
    bit sink_gaps;
    bit hold_sink;

    humidity_temp_frame_decoder_unit #(
        .AGE_BITS (AGE_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    htfd_checker #(
        .AGE_BITS (AGE_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_m_tlast     (o_m_tlast),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // offer one word, optionally after an idle burst, and wait until it is taken
    task automatic send_word(input logic op, input logic [7:0] data, input logic start);
        int gap;
        if (src_gaps && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= {start, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        words_sent++;
    endtask

    // six-byte response; a nonzero flip corrupts that crc byte
    task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input logic [7:0] t_flip, input logic [7:0] h_flip,
                              input int n_bytes, input logic marked, input bit with_ticks);
        logic [7:0] frame [0:5];
        frame = '{t_raw[15:8], t_raw[7:0], sensor_crc8(t_raw) ^ t_flip,
                  h_raw[15:8], h_raw[7:0], sensor_crc8(h_raw) ^ h_flip};
        for (int k = 0; k < n_bytes; k++) begin
            // ticks between bytes leave the byte position alone
            if (with_ticks && $urandom_range(0, 9) == 0) begin
                send_word(OP_TICK, 8'($urandom), 1'($urandom));
            end
            send_word(OP_BYTE, frame[k], marked && k == 0);
        end
    endtask

    // raw sensor word, biased toward the ends of the range
    function automatic logic [15:0] pick_raw();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            return 16'h0000;
        end else if (sel == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    // mostly clean responses, the rest broken, cut short, unmarked, ticks or noise
    task automatic send_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            send_frame(pick_raw(), pick_raw(), 8'h00, 8'h00, 6, 1'b1, 1'b1);
        end else if (kind < 70) begin
            n = $urandom_range(0, 2);
            send_frame(pick_raw(), pick_raw(),
                       (n != 1) ? 8'($urandom_range(1, 255)) : 8'h00,
                       (n != 0) ? 8'($urandom_range(1, 255)) : 8'h00, 6, 1'b1, 1'b1);
        end else if (kind < 78) begin
            send_frame(pick_raw(), pick_raw(), 8'h00, 8'h00, $urandom_range(1, 5), 1'b1, 1'b1);
        end else if (kind < 85) begin
            send_frame(pick_raw(), pick_raw(), 8'h00, 8'h00, 6, 1'b0, 1'b1);
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 10)) send_word(OP_TICK, 8'($urandom), 1'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) send_word(1'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    // drop valid and wait until every result word has come back
    task automatic settle_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_sensor_enable(input logic value);
        settle_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stall bursts, one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_m_tready <= 1'b0;
                repeat (SINK_HOLD - 1) @(negedge i_clk);
                hold_sink = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // end the run when nothing moves on any channel for too long
    initial begin
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // stimulus and verdict
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 8'h00;
        i_s_tuser   = 2'b00;
        src_gaps    = 1'b0;
        sink_gaps   = 1'b0;
        hold_sink   = 1'b0;
        words_sent  = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tick before any reading, range ends, bad crc, dropped partial
        write_sensor_enable(1'b1);
        send_word(OP_TICK, 8'hFF, 1'b1);
        send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 6, 1'b1, 1'b0);
        send_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 6, 1'b1, 1'b0);
        send_frame(16'h6666, 16'h8000, 8'h01, 8'h00, 6, 1'b1, 1'b0);
        send_frame(16'hA5A5, 16'h5A5A, 8'h00, 8'h00, 2, 1'b1, 1'b0);
        // below zero, where the scaled value truncates toward zero
        send_frame(16'h1234, 16'h0001, 8'h00, 8'h00, 6, 1'b1, 1'b0);

        // sensor off: bytes ignored, ticks still count
        write_sensor_enable(1'b0);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        while (words_sent < 180) send_random_sequence();
        write_sensor_enable(1'b1);
        while (words_sent < 700) send_random_sequence();

        // long result hold-off while words keep coming back to back
        src_gaps  = 1'b0;
        hold_sink = 1'b1;
        while (words_sent < 780) send_random_sequence();
        src_gaps  = 1'b1;

        write_sensor_enable(1'b0);
        while (words_sent < 900) send_random_sequence();
        write_sensor_enable(1'b1);
        while (words_sent < 1500) send_random_sequence();

        // closing stretch with no idling on either side
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        while (words_sent < 1700) send_random_sequence();

        settle_idle();
        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
